// ----- rtl/ssfc_pkg.sv -----
package ssfc_pkg;

  localparam int WORD_BITS   = 32;
  localparam int COUNT_BITS  = 8;
  localparam int SET_BITS    = 8;
  localparam int POS_BITS    = 9;
  localparam int SAMPLE_BITS = 9;
  localparam int MAX_SAMPLES = 255;

  localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

  localparam int BIT_INDIC  = 31;
  localparam int BIT_PFLAG  = 29;
  localparam int BIT_READ   = 28;
  localparam int BIT_TEC_HI = 27;
  localparam int BIT_TEC_LO = 25;
  localparam int BIT_DOUBLE = 24;
  localparam int BIT_SINGLE = 23;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_INDIC  = 3'd1,
    ST_PARITY = 3'd2,
    ST_READ   = 3'd3,
    ST_TEC    = 3'd4,
    ST_SINGLE = 3'd5,
    ST_DOUBLE = 3'd6
  } status_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SMP_HDR_FLAG = -9'sd2;
  localparam sample_t SMP_VERT     = -9'sd1;
  localparam sample_t SMP_HEADER   = 9'sd0;

  typedef enum logic {
    REG_SAMPLE_COUNT = 1'b0,
    REG_VERT_ENABLE  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic    err;
    status_t status;
    sample_t sample;
  } hdr_result_t;

endpackage

// ----- rtl/ssfc_hdr_check.sv -----
module ssfc_hdr_check (
  input  logic [ssfc_pkg::WORD_BITS-1:0] header,
  output ssfc_pkg::hdr_result_t          result
);
  import ssfc_pkg::*;

  always_comb begin
    result = '{err: 1'b1, status: ST_OK, sample: SMP_HEADER};
    priority if (!header[BIT_INDIC]) begin
      result.status = ST_INDIC;
    end else if (header[BIT_PFLAG]) begin
      result.status = ST_PARITY;
      result.sample = SMP_HDR_FLAG;
    end else if (header[BIT_READ]) begin
      result.status = ST_READ;
    end else if (|header[BIT_TEC_HI:BIT_TEC_LO]) begin
      result.status = ST_TEC;
    end else if (header[BIT_DOUBLE]) begin
      result.status = ST_DOUBLE;
    end else if (header[BIT_SINGLE]) begin
      result.status = ST_SINGLE;
    end else if (^header) begin
      result.status = ST_PARITY;
    end else begin
      result.err = 1'b0;
    end
  end

endmodule

// ----- rtl/sample_set_frame_checker_core.sv -----
// Channel   Signals                                     Direction
// word      word_valid word_ready word set_index        in
// result    result_valid result_ready status
//           error_set error_sample                      out
// config    psel penable pwrite paddr pwdata prdata pready
//
// One word is taken per cycle while word_ready is high; the frame state updates in the cycle the word is taken.
// A result sits in the output register from the cycle after the last word of a set.
// Words stall only while a result is held and result_ready is low.
// Reset clears the frame position and the result valid flag and sets the registers to defaults.
module sample_set_frame_checker_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           word_valid,
  output logic                           word_ready,
  input  logic [ssfc_pkg::WORD_BITS-1:0] word,
  input  logic [ssfc_pkg::SET_BITS-1:0]  set_index,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [2:0]                     status,
  output logic [ssfc_pkg::SET_BITS-1:0]  error_set,
  output logic signed [8:0]              error_sample,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ssfc_pkg::*;

  logic [COUNT_BITS-1:0] sample_count;
  logic                  vertical_check_enable;

  logic [POS_BITS-1:0]   position;
  logic [WORD_BITS-1:0]  vertical_accumulator;
  logic                  error_seen;
  status_t               first_status;
  sample_t               first_sample;
  logic [SET_BITS-1:0]   latched_set;

  status_t               status_reg;
  sample_t               sample_reg;

  logic                  cfg_write;
  reg_index_t            cfg_index;
  logic                  word_take;
  logic [COUNT_BITS-1:0] limit;
  logic                  at_header;
  logic                  at_last;
  logic [WORD_BITS-1:0]  acc_next;
  logic                  vert_err;
  hdr_result_t           hdr;

  ssfc_hdr_check u_hdr (
    .header(word),
    .result(hdr)
  );

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[2]);

  always_comb begin
    unique case (cfg_index)
      REG_SAMPLE_COUNT: prdata = {{(32-COUNT_BITS){1'b0}}, sample_count};
      REG_VERT_ENABLE:  prdata = {31'd0, vertical_check_enable};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count          <= COUNT_BITS'(16);
      vertical_check_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SAMPLE_COUNT: sample_count          <= pwdata[COUNT_BITS-1:0];
        REG_VERT_ENABLE:  vertical_check_enable <= pwdata[0];
        default:          ;
      endcase
    end
  end

  assign word_ready = !result_valid || result_ready;
  assign word_take  = word_valid && word_ready;
  assign limit      = (sample_count > COUNT_BITS'(MAX_SAMPLES)) ?
                      COUNT_BITS'(MAX_SAMPLES) : sample_count;
  assign at_header  = (position == '0);
  assign at_last    = !at_header && (position > {1'b0, limit});
  assign acc_next   = vertical_accumulator ^ word;
  assign vert_err   = vertical_check_enable && (acc_next != ALL_ONES);

  always_ff @(posedge clk) begin
    if (rst) begin
      position             <= '0;
      vertical_accumulator <= '0;
      error_seen           <= 1'b0;
      first_status         <= ST_OK;
      first_sample         <= SMP_HEADER;
      latched_set          <= '0;
      result_valid         <= 1'b0;
    end else begin
      if (word_take && at_last) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (word_take) begin
        priority if (at_header) begin
          latched_set          <= set_index;
          vertical_accumulator <= word;
          error_seen           <= hdr.err;
          first_status         <= hdr.err ? hdr.status : ST_OK;
          first_sample         <= hdr.err ? hdr.sample : SMP_HEADER;
          position             <= POS_BITS'(1);
        end else if (!at_last) begin
          if (!error_seen && ^word) begin
            error_seen   <= 1'b1;
            first_status <= ST_PARITY;
            first_sample <= sample_t'(position);
          end
          vertical_accumulator <= acc_next;
          position             <= position + POS_BITS'(1);
        end else begin
          position             <= '0;
          vertical_accumulator <= '0;
          error_seen           <= 1'b0;
          first_status         <= ST_OK;
          first_sample         <= SMP_HEADER;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (word_take && at_last) begin
      error_set <= latched_set;
      priority if (error_seen) begin
        status_reg <= first_status;
        sample_reg <= first_sample;
      end else if (vert_err) begin
        status_reg <= ST_PARITY;
        sample_reg <= SMP_VERT;
      end else begin
        status_reg <= ST_OK;
        sample_reg <= SMP_HEADER;
      end
    end
  end

  assign status       = status_reg;
  assign error_sample = sample_reg;

  assert property (@(posedge clk) disable iff (rst)
    position <= POS_BITS'(MAX_SAMPLES + 1))
    else $error("frame position past last word");

  assert property (@(posedge clk) disable iff (rst)
    word_take && at_header |=> position == POS_BITS'(1))
    else $error("header did not advance frame");

  assert property (@(posedge clk) disable iff (rst)
    word_take && at_last |=> result_valid && position == '0)
    else $error("last word did not close the set");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && status_reg == ST_OK |-> sample_reg == SMP_HEADER)
    else $error("ok result with nonzero sample");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && sample_reg < 0 |-> status_reg == ST_PARITY)
    else $error("negative sample without parity status");

endmodule
